// ===== src/assert_macros.svh =====
// assertion macros for the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off while reset is high
`define ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

// next-cycle implication, off while reset is high
`define ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

// ===== src/llag_pkg.sv =====
// shared widths, codes and types of the life-like automaton grid
// no dependencies
`default_nettype none

package llag_pkg;

   localparam int CMD_W      = 2;
   localparam int COORD_W    = 6;
   localparam int SIZE_W     = 7;
   localparam int MASK_W     = 9;
   localparam int NBR_W      = 4;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 9;

   localparam logic [CMD_W-1:0] CMD_SET  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_GET  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_STEP = 2'd2;
   localparam logic [CMD_W-1:0] CMD_FILL = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_GRID_COLS    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_ROWS    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BIRTH_MASK   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SURVIVE_MASK = 3'd3;

   localparam logic [SIZE_W-1:0] GRID_COLS_RST    = 7'd64;
   localparam logic [SIZE_W-1:0] GRID_ROWS_RST    = 7'd64;
   localparam logic [MASK_W-1:0] BIRTH_MASK_RST   = 9'd8;
   localparam logic [MASK_W-1:0] SURVIVE_MASK_RST = 9'd12;

   // 3x3 neighborhood, each column is {bottom, center, top}
   typedef struct packed {
      logic [2:0] lft;
      logic [2:0] mid;
      logic [2:0] rgt;
   } window_type;

endpackage

`default_nettype wire

// ===== src/life_like_automaton_grid_unit.sv =====
// life-like automaton grid: cell store, next-generation store and command sequencer
// depends on llag_pkg and llag_rule
`default_nettype none

// A command is taken when start is high and busy is low; each command gives one
// result strobe on rsp_valid in the cycle after it finishes, and the receiver cannot
// stall it. Set and get keep busy low, so they can follow each other every cycle.
// Fill sweeps the whole store, one entry a cycle. Step with a used grid of w columns
// and h rows first runs the neighborhood pass over w+1 columns of each row (three
// reads of the single cell-store read port per column, then a shift of the window
// and a write of the next-state store), then copies the new generation back, then
// drains the last copy write; an empty grid answers at once and busy stays low.
// After reset the cell store is cleared by a pass over every entry with busy high;
// configuration writes are taken at any time.
module life_like_automaton_grid_unit #(
   parameter int MAX_COLS = 64,
   parameter int MAX_ROWS = 64
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               start,
   output logic                                    busy,
   input  wire logic [llag_pkg::CMD_W-1:0]         req_cmd,
   input  wire logic [llag_pkg::COORD_W-1:0]       req_col,
   input  wire logic [llag_pkg::COORD_W-1:0]       req_row,
   input  wire logic                               req_new_value,
   output logic                                    rsp_valid,
   output logic                                    rsp_ok,
   output logic                                    rsp_read_value,
   input  wire logic                               csr_valid,
   output logic                                    csr_ready,
   input  wire logic [llag_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [llag_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   localparam int STORE_DEPTH = MAX_COLS * MAX_ROWS;
   localparam int ADDR_W     = $clog2(STORE_DEPTH);
   localparam int COL_W      = $clog2(MAX_COLS + 1);
   localparam int ROW_W      = $clog2(MAX_ROWS + 1);
   localparam int CMP_C_W    = (COL_W > llag_pkg::SIZE_W) ? COL_W : llag_pkg::SIZE_W;
   localparam int CMP_R_W    = (ROW_W > llag_pkg::SIZE_W) ? ROW_W : llag_pkg::SIZE_W;
   localparam logic [CMP_C_W-1:0] MAX_C_EXT = CMP_C_W'(MAX_COLS);
   localparam logic [CMP_R_W-1:0] MAX_R_EXT = CMP_R_W'(MAX_ROWS);
   localparam logic [ADDR_W-1:0]  LAST_ADDR = ADDR_W'(STORE_DEPTH - 1);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_FILL   = 3'd1;
   localparam logic [2:0] ST_STEP   = 3'd2;
   localparam logic [2:0] ST_COMMIT = 3'd3;
   localparam logic [2:0] ST_DRAIN  = 3'd4;

   localparam logic [1:0] PH_TOP    = 2'd0;
   localparam logic [1:0] PH_CENTER = 2'd1;
   localparam logic [1:0] PH_BOTTOM = 2'd2;
   localparam logic [1:0] PH_SHIFT  = 2'd3;

   function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] r,
                                                   input logic [COL_W-1:0] c);
      return ADDR_W'(r * MAX_COLS + c);
   endfunction

   // configuration
   logic [llag_pkg::SIZE_W-1:0] grid_cols_ff, grid_rows_ff;
   logic [llag_pkg::MASK_W-1:0] birth_mask_ff, survive_mask_ff;

   // sequencer
   logic [2:0]         state_ff, state_in;
   logic [ADDR_W-1:0]  fill_ff, fill_in;
   logic               fill_val_ff, fill_val_in;
   logic               fill_rsp_ff, fill_rsp_in;
   logic [ROW_W-1:0]   sr_ff, sr_in;
   logic [COL_W-1:0]   sk_ff, sk_in;
   logic [1:0]         sp_ff, sp_in;
   llag_pkg::window_type win_ff, win_in, win_shift;
   logic               top_ff, top_in;
   logic               ctr_ff, ctr_in;
   logic               live_ff, live_in;
   logic               cpend_ff, cpend_in;
   logic [ADDR_W-1:0]  cpend_addr_ff, cpend_addr_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_ok_ff, rsp_ok_in;
   logic               rsp_rd_sel_ff, rsp_rd_sel_in;

   // memories
   logic               cell_mem [STORE_DEPTH];
   logic               next_mem [STORE_DEPTH];
   logic               cell_rdata_ff, next_rdata_ff;
   logic               cm_we, cm_wdata, cm_re;
   logic [ADDR_W-1:0]  cm_waddr, cm_raddr;
   logic               nm_we, nm_wdata, nm_re;
   logic [ADDR_W-1:0]  nm_waddr, nm_raddr;

   // derived
   logic [COL_W-1:0]   used_cols;
   logic [ROW_W-1:0]   used_rows;
   logic [CMP_C_W-1:0] gc_ext;
   logic [CMP_R_W-1:0] gr_ext;
   logic               accept, grid_empty, req_in_grid;
   logic [ADDR_W-1:0]  req_addr;
   logic [ROW_W-1:0]   step_row;
   logic               row_ok, step_live, bottom_bit, rule_next;

   assign accept    = start & ~busy;
   assign busy      = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_ok    = rsp_ok_ff;
   assign rsp_read_value = rsp_rd_sel_ff & cell_rdata_ff;

   always_comb begin
      gc_ext     = CMP_C_W'(grid_cols_ff);
      gr_ext     = CMP_R_W'(grid_rows_ff);
      used_cols  = COL_W'((gc_ext > MAX_C_EXT) ? MAX_C_EXT : gc_ext);
      used_rows  = ROW_W'((gr_ext > MAX_R_EXT) ? MAX_R_EXT : gr_ext);
      grid_empty = (used_cols == '0) || (used_rows == '0);
      req_in_grid = (CMP_C_W'(req_col) < CMP_C_W'(used_cols))
                 && (CMP_R_W'(req_row) < CMP_R_W'(used_rows));
      req_addr   = cell_addr(ROW_W'(req_row), COL_W'(req_col));
   end

   // row above, at or below the current one, depending on the phase
   always_comb begin
      step_row = sr_ff + ROW_W'(sp_ff) - ROW_W'(1);
      unique case (sp_ff)
         PH_TOP:    row_ok = (sr_ff != '0);
         PH_CENTER: row_ok = 1'b1;
         PH_BOTTOM: row_ok = ((sr_ff + ROW_W'(1)) < used_rows);
         default:   row_ok = 1'b0;
      endcase
      step_live  = row_ok && (sk_ff < used_cols);
      bottom_bit = cell_rdata_ff & live_ff;
      win_shift.lft = win_ff.mid;
      win_shift.mid = win_ff.rgt;
      win_shift.rgt = {bottom_bit, ctr_ff, top_ff};
   end

   llag_rule u_rule (
      .win          (win_shift),
      .birth_mask   (birth_mask_ff),
      .survive_mask (survive_mask_ff),
      .next_alive   (rule_next)
   );

   always_comb begin
      state_in      = state_ff;
      fill_in       = fill_ff;
      fill_val_in   = fill_val_ff;
      fill_rsp_in   = fill_rsp_ff;
      sr_in         = sr_ff;
      sk_in         = sk_ff;
      sp_in         = sp_ff;
      win_in        = win_ff;
      top_in        = top_ff;
      ctr_in        = ctr_ff;
      live_in       = 1'b0;
      cpend_in      = 1'b0;
      cpend_addr_in = cpend_addr_ff;
      rsp_valid_in  = 1'b0;
      rsp_ok_in     = 1'b1;
      rsp_rd_sel_in = 1'b0;
      cm_we    = 1'b0;
      cm_waddr = '0;
      cm_wdata = 1'b0;
      cm_re    = 1'b0;
      cm_raddr = '0;
      nm_we    = 1'b0;
      nm_waddr = '0;
      nm_wdata = 1'b0;
      nm_re    = 1'b0;
      nm_raddr = '0;

      // copy-back write, in the cycle after its read of the next-state store
      if (cpend_ff) begin
         cm_we    = 1'b1;
         cm_waddr = cpend_addr_ff;
         cm_wdata = next_rdata_ff;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_cmd)
                  llag_pkg::CMD_SET: begin
                     rsp_valid_in = 1'b1;
                     rsp_ok_in    = req_in_grid;
                     if (req_in_grid) begin
                        cm_we    = 1'b1;
                        cm_waddr = req_addr;
                        cm_wdata = req_new_value;
                     end
                  end
                  llag_pkg::CMD_GET: begin
                     rsp_valid_in  = 1'b1;
                     rsp_ok_in     = req_in_grid;
                     rsp_rd_sel_in = req_in_grid;
                     cm_re         = req_in_grid;
                     cm_raddr      = req_addr;
                  end
                  llag_pkg::CMD_STEP: begin
                     if (grid_empty) begin
                        rsp_valid_in = 1'b1;
                     end else begin
                        state_in = ST_STEP;
                        sr_in    = '0;
                        sk_in    = '0;
                        sp_in    = PH_TOP;
                        win_in   = '0;
                     end
                  end
                  default: begin
                     state_in    = ST_FILL;
                     fill_in     = '0;
                     fill_val_in = req_new_value;
                     fill_rsp_in = 1'b1;
                  end
               endcase
            end
         end
         ST_FILL: begin
            cm_we    = 1'b1;
            cm_waddr = fill_ff;
            cm_wdata = fill_val_ff;
            fill_in  = fill_ff + ADDR_W'(1);
            if (fill_ff == LAST_ADDR) begin
               state_in     = ST_IDLE;
               rsp_valid_in = fill_rsp_ff;
            end
         end
         ST_STEP: begin
            if (sp_ff != PH_SHIFT) begin
               cm_re    = step_live;
               cm_raddr = cell_addr(step_row, sk_ff);
               live_in  = step_live;
               sp_in    = sp_ff + 2'd1;
            end
            if (sp_ff == PH_CENTER) begin
               top_in = cell_rdata_ff & live_ff;
            end
            if (sp_ff == PH_BOTTOM) begin
               ctr_in = cell_rdata_ff & live_ff;
            end
            if (sp_ff == PH_SHIFT) begin
               win_in = win_shift;
               sp_in  = PH_TOP;
               // window now centers on the column left of the one just loaded
               if (sk_ff != '0) begin
                  nm_we    = 1'b1;
                  nm_waddr = cell_addr(sr_ff, sk_ff - COL_W'(1));
                  nm_wdata = rule_next;
               end
               if (sk_ff == used_cols) begin
                  sk_in  = '0;
                  win_in = '0;
                  if (sr_ff == used_rows - ROW_W'(1)) begin
                     state_in = ST_COMMIT;
                     sr_in    = '0;
                  end else begin
                     sr_in = sr_ff + ROW_W'(1);
                  end
               end else begin
                  sk_in = sk_ff + COL_W'(1);
               end
            end
         end
         ST_COMMIT: begin
            nm_re         = 1'b1;
            nm_raddr      = cell_addr(sr_ff, sk_ff);
            cpend_in      = 1'b1;
            cpend_addr_in = cell_addr(sr_ff, sk_ff);
            if (sk_ff == used_cols - COL_W'(1)) begin
               sk_in = '0;
               if (sr_ff == used_rows - ROW_W'(1)) begin
                  state_in = ST_DRAIN;
               end else begin
                  sr_in = sr_ff + ROW_W'(1);
               end
            end else begin
               sk_in = sk_ff + COL_W'(1);
            end
         end
         ST_DRAIN: begin
            state_in     = ST_IDLE;
            rsp_valid_in = 1'b1;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_FILL;
         fill_ff         <= '0;
         fill_val_ff     <= 1'b0;
         fill_rsp_ff     <= 1'b0;
         sp_ff           <= PH_TOP;
         live_ff         <= 1'b0;
         cpend_ff        <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         rsp_rd_sel_ff   <= 1'b0;
         grid_cols_ff    <= llag_pkg::GRID_COLS_RST;
         grid_rows_ff    <= llag_pkg::GRID_ROWS_RST;
         birth_mask_ff   <= llag_pkg::BIRTH_MASK_RST;
         survive_mask_ff <= llag_pkg::SURVIVE_MASK_RST;
      end else begin
         state_ff      <= state_in;
         fill_ff       <= fill_in;
         fill_val_ff   <= fill_val_in;
         fill_rsp_ff   <= fill_rsp_in;
         sp_ff         <= sp_in;
         live_ff       <= live_in;
         cpend_ff      <= cpend_in;
         rsp_valid_ff  <= rsp_valid_in;
         rsp_rd_sel_ff <= rsp_rd_sel_in;
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               llag_pkg::CSR_GRID_COLS:
                  grid_cols_ff <= csr_wdata[llag_pkg::SIZE_W-1:0];
               llag_pkg::CSR_GRID_ROWS:
                  grid_rows_ff <= csr_wdata[llag_pkg::SIZE_W-1:0];
               llag_pkg::CSR_BIRTH_MASK:
                  birth_mask_ff <= csr_wdata[llag_pkg::MASK_W-1:0];
               llag_pkg::CSR_SURVIVE_MASK:
                  survive_mask_ff <= csr_wdata[llag_pkg::MASK_W-1:0];
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      sr_ff         <= sr_in;
      sk_ff         <= sk_in;
      win_ff        <= win_in;
      top_ff        <= top_in;
      ctr_ff        <= ctr_in;
      cpend_addr_ff <= cpend_addr_in;
      rsp_ok_ff     <= rsp_ok_in;
   end

   always_ff @(posedge clock) begin
      if (cm_we) begin
         cell_mem[cm_waddr] <= cm_wdata;
      end
      if (cm_re) begin
         cell_rdata_ff <= cell_mem[cm_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (nm_we) begin
         next_mem[nm_waddr] <= nm_wdata;
      end
      if (nm_re) begin
         next_rdata_ff <= next_mem[nm_raddr];
      end
   end

endmodule

`default_nettype wire

// ===== src/llag_rule.sv =====
// next-state rule for one cell from its 3x3 neighborhood and the b/s masks
// depends on llag_pkg
`default_nettype none

module llag_rule (
   input  var llag_pkg::window_type         win,
   input  wire logic [llag_pkg::MASK_W-1:0] birth_mask,
   input  wire logic [llag_pkg::MASK_W-1:0] survive_mask,
   output logic                             next_alive
);

   logic [llag_pkg::NBR_W-1:0] count;

   always_comb begin
      count = llag_pkg::NBR_W'(win.lft[0]) + llag_pkg::NBR_W'(win.lft[1])
            + llag_pkg::NBR_W'(win.lft[2]) + llag_pkg::NBR_W'(win.mid[0])
            + llag_pkg::NBR_W'(win.mid[2]) + llag_pkg::NBR_W'(win.rgt[0])
            + llag_pkg::NBR_W'(win.rgt[1]) + llag_pkg::NBR_W'(win.rgt[2]);
      next_alive = win.mid[1] ? survive_mask[count] : birth_mask[count];
   end

endmodule

`default_nettype wire

// ===== src/llag_checker.sv =====
// port-level checks on the automaton grid unit, bound into the grid unit module
// depends on llag_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module llag_checker (
   input wire logic                               clock,
   input wire logic                               reset,
   input wire logic                               start,
   input wire logic                               busy,
   input wire logic [llag_pkg::CMD_W-1:0]         req_cmd,
   input wire logic                               rsp_valid,
   input wire logic                               rsp_ok,
   input wire logic                               rsp_read_value
);

   logic accept, quick_cmd, long_cmd;

   assign accept    = start & ~busy;
   assign quick_cmd = (req_cmd == llag_pkg::CMD_SET) || (req_cmd == llag_pkg::CMD_GET);
   assign long_cmd  = (req_cmd == llag_pkg::CMD_STEP) || (req_cmd == llag_pkg::CMD_FILL);

   // set and get answer in the very next cycle
   `ASSERT_NXT(a_quick_beat, clock, reset, accept && quick_cmd, rsp_valid)

   // a step or fill either keeps the unit busy or, for an empty grid, answers at once
   `ASSERT_NXT(a_long_busy, clock, reset, accept && long_cmd, busy || rsp_valid)

   // no result beat while a long command is still running
   `ASSERT_IMP(a_no_beat_busy, clock, reset, busy, !rsp_valid)

   // a read value only comes with a successful beat
   `ASSERT_IMP(a_read_ok, clock, reset, rsp_read_value, rsp_valid && rsp_ok)

endmodule

bind life_like_automaton_grid_unit llag_checker u_llag_checker (.*);

`default_nettype wire

// ===== tb/sv/life_like_automaton_grid_unit_tb.sv =====
// testbench of life_like_automaton_grid_unit: directed and random commands against a
// bit-level predictor of the grid, one expected reply per command, checked in order
// depends on llag_pkg and the life_like_automaton_grid_unit rtl
`default_nettype none

module life_like_automaton_grid_unit_tb;

   localparam int GRID_MAX_COLS  = 64;
   localparam int GRID_MAX_ROWS  = 64;
   localparam int STORE_CELLS    = GRID_MAX_COLS * GRID_MAX_ROWS;
   localparam int WATCHDOG_LIMIT = 100000;
   localparam int REPORT_LIMIT   = 10;
   localparam int RANDOM_PHASES  = 6;
   localparam int PHASE_ITEMS    = 18;

   typedef struct packed {
      logic ok;
      logic read_value;
   } cell_reply_type;

   logic                            clock          = 1'b0;
   logic                            reset          = 1'b1;
   logic                            start          = 1'b0;
   logic [llag_pkg::CMD_W-1:0]      req_cmd        = llag_pkg::CMD_GET;
   logic [llag_pkg::COORD_W-1:0]    req_col        = '0;
   logic [llag_pkg::COORD_W-1:0]    req_row        = '0;
   logic                            req_new_value  = 1'b0;
   logic                            csr_valid      = 1'b0;
   logic [llag_pkg::CSR_IDX_W-1:0]  csr_index      = '0;
   logic [llag_pkg::CSR_DATA_W-1:0] csr_wdata      = '0;
   logic                            busy;
   logic                            rsp_valid;
   logic                            rsp_ok;
   logic                            rsp_read_value;
   logic                            csr_ready;

   // predicted grid and registers
   bit                            cell_model [STORE_CELLS];
   bit                            next_model [STORE_CELLS];
   logic [llag_pkg::SIZE_W-1:0]   model_cols    = llag_pkg::GRID_COLS_RST;
   logic [llag_pkg::SIZE_W-1:0]   model_rows    = llag_pkg::GRID_ROWS_RST;
   logic [llag_pkg::MASK_W-1:0]   model_birth   = llag_pkg::BIRTH_MASK_RST;
   logic [llag_pkg::MASK_W-1:0]   model_survive = llag_pkg::SURVIVE_MASK_RST;

   cell_reply_type        awaited_replies [$];
   int                    mismatch_count = 0;
   int                    burst_left     = 0;
   int                    idle_cycles    = 0;

   life_like_automaton_grid_unit #(
      .MAX_COLS(GRID_MAX_COLS),
      .MAX_ROWS(GRID_MAX_ROWS)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_cmd(req_cmd),
      .req_col(req_col),
      .req_row(req_row),
      .req_new_value(req_new_value),
      .rsp_valid(rsp_valid),
      .rsp_ok(rsp_ok),
      .rsp_read_value(rsp_read_value),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   function automatic int cols_in_use();
      return (model_cols > GRID_MAX_COLS) ? GRID_MAX_COLS : int'(model_cols);
   endfunction

   function automatic int rows_in_use();
      return (model_rows > GRID_MAX_ROWS) ? GRID_MAX_ROWS : int'(model_rows);
   endfunction

   function automatic bit in_grid(int c, int r);
      return c >= 0 && r >= 0 && c < cols_in_use() && r < rows_in_use();
   endfunction

   function automatic void report_failure(string msg);
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT) $display("mismatch: %s", msg);
   endfunction

   // whole new generation from the old grid, then commit; cells past the grid keep
   function automatic void advance_generation();
      int                          w;
      int                          h;
      int                          live;
      int                          idx;
      logic [llag_pkg::MASK_W-1:0] mask_bits;
      w = cols_in_use();
      h = rows_in_use();
      for (int r = 0; r < h; r++) begin
         for (int c = 0; c < w; c++) begin
            live = 0;
            for (int dr = -1; dr <= 1; dr++) begin
               for (int dc = -1; dc <= 1; dc++) begin
                  if (!(dr == 0 && dc == 0) && in_grid(c + dc, r + dr)) begin
                     if (cell_model[(r + dr) * GRID_MAX_COLS + c + dc]) live++;
                  end
               end
            end
            idx = r * GRID_MAX_COLS + c;
            mask_bits = cell_model[idx] ? model_survive : model_birth;
            next_model[idx] = mask_bits[live];
         end
      end
      for (int r = 0; r < h; r++) begin
         for (int c = 0; c < w; c++) begin
            cell_model[r * GRID_MAX_COLS + c] = next_model[r * GRID_MAX_COLS + c];
         end
      end
   endfunction

   function automatic void predict_reply(logic [llag_pkg::CMD_W-1:0] cmd,
                                         logic [llag_pkg::COORD_W-1:0] col,
                                         logic [llag_pkg::COORD_W-1:0] row, logic val);
      cell_reply_type reply;
      int             idx;
      reply.ok = 1'b1;
      reply.read_value = 1'b0;
      idx = int'(row) * GRID_MAX_COLS + int'(col);
      case (cmd)
         llag_pkg::CMD_SET: begin
            if (in_grid(col, row)) cell_model[idx] = val;
            else reply.ok = 1'b0;
         end
         llag_pkg::CMD_GET: begin
            if (in_grid(col, row)) reply.read_value = cell_model[idx];
            else reply.ok = 1'b0;
         end
         llag_pkg::CMD_STEP: advance_generation();
         default: begin
            foreach (cell_model[i]) cell_model[i] = val;
         end
      endcase
      awaited_replies.push_back(reply);
   endfunction

   function automatic void apply_register_write(logic [llag_pkg::CSR_IDX_W-1:0] idx,
                                                logic [llag_pkg::CSR_DATA_W-1:0] data);
      case (idx)
         llag_pkg::CSR_GRID_COLS:    model_cols = data[llag_pkg::SIZE_W-1:0];
         llag_pkg::CSR_GRID_ROWS:    model_rows = data[llag_pkg::SIZE_W-1:0];
         llag_pkg::CSR_BIRTH_MASK:   model_birth = data[llag_pkg::MASK_W-1:0];
         llag_pkg::CSR_SURVIVE_MASK: model_survive = data[llag_pkg::MASK_W-1:0];
         default: ;
      endcase
   endfunction

   // one command beat; the sender keeps start high within a burst
   task automatic send_item(input logic [llag_pkg::CMD_W-1:0] cmd,
                            input logic [llag_pkg::COORD_W-1:0] col,
                            input logic [llag_pkg::COORD_W-1:0] row, input logic val);
      start <= 1'b1;
      req_cmd <= cmd;
      req_col <= col;
      req_row <= row;
      req_new_value <= val;
      do @(posedge clock); while (busy !== 1'b0);
      predict_reply(cmd, col, row, val);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         start <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 25)
                                                  : $urandom_range(0, 5);
      end
   endtask

   task automatic wait_until_quiet();
      start <= 1'b0;
      while (awaited_replies.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_register(input logic [llag_pkg::CSR_IDX_W-1:0] idx,
                                 input logic [llag_pkg::CSR_DATA_W-1:0] data);
      wait_until_quiet();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (csr_ready !== 1'b1);
      apply_register_write(idx, data);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [llag_pkg::COORD_W-1:0] coord_within(int extent);
      return (extent > 0) ? llag_pkg::COORD_W'($urandom_range(0, extent - 1))
                          : llag_pkg::COORD_W'($urandom);
   endfunction

   task automatic test_reset_state();
      do @(posedge clock); while (busy !== 1'b0);
      send_item(llag_pkg::CMD_GET, 6'd0, 6'd0, 1'b0);
      send_item(llag_pkg::CMD_GET, 6'd63, 6'd63, 1'b1);
   endtask

   task automatic test_set_get_corners();
      send_item(llag_pkg::CMD_SET, 6'd63, 6'd63, 1'b1);
      send_item(llag_pkg::CMD_SET, 6'd0, 6'd0, 1'b1);
      send_item(llag_pkg::CMD_SET, 6'd42, 6'd21, 1'b1);
      send_item(llag_pkg::CMD_GET, 6'd63, 6'd63, 1'b0);
      send_item(llag_pkg::CMD_GET, 6'd42, 6'd21, 1'b0);
      send_item(llag_pkg::CMD_SET, 6'd42, 6'd21, 1'b0);
      send_item(llag_pkg::CMD_GET, 6'd21, 6'd42, 1'b0);
   endtask

   task automatic test_fill_store();
      send_item(llag_pkg::CMD_FILL, 6'd0, 6'd0, 1'b1);
      send_item(llag_pkg::CMD_GET, 6'd13, 6'd50, 1'b0);
      send_item(llag_pkg::CMD_FILL, 6'd63, 6'd63, 1'b0);
   endtask

   // blinker against the top edge of the full grid
   task automatic test_edge_step_full_grid();
      send_item(llag_pkg::CMD_SET, 6'd1, 6'd0, 1'b1);
      send_item(llag_pkg::CMD_SET, 6'd1, 6'd1, 1'b1);
      send_item(llag_pkg::CMD_SET, 6'd1, 6'd2, 1'b1);
      send_item(llag_pkg::CMD_STEP, 6'd0, 6'd0, 1'b0);
      send_item(llag_pkg::CMD_GET, 6'd0, 6'd1, 1'b0);
   endtask

   task automatic test_out_of_grid_cells();
      send_item(llag_pkg::CMD_SET, 6'd10, 6'd10, 1'b1);
      write_register(llag_pkg::CSR_GRID_COLS, 9'd5);
      write_register(llag_pkg::CSR_GRID_ROWS, 9'd3);
      send_item(llag_pkg::CMD_SET, 6'd5, 6'd0, 1'b1);
      send_item(llag_pkg::CMD_SET, 6'd0, 6'd3, 1'b1);
      send_item(llag_pkg::CMD_GET, 6'd63, 6'd63, 1'b0);
      send_item(llag_pkg::CMD_STEP, 6'd0, 6'd0, 1'b0);
      write_register(llag_pkg::CSR_GRID_COLS, 9'd64);
      write_register(llag_pkg::CSR_GRID_ROWS, 9'd64);
      // a lone cell past the shrunk grid must have kept its value
      send_item(llag_pkg::CMD_GET, 6'd10, 6'd10, 1'b0);
   endtask

   task automatic test_size_extremes();
      write_register(llag_pkg::CSR_GRID_COLS, 9'd0);
      send_item(llag_pkg::CMD_SET, 6'd0, 6'd0, 1'b1);
      send_item(llag_pkg::CMD_STEP, 6'd0, 6'd0, 1'b0);
      // oversized width wraps to 127 in the register and acts as the full store
      write_register(llag_pkg::CSR_GRID_COLS, 9'h1FF);
      write_register(llag_pkg::CSR_GRID_ROWS, 9'd2);
      send_item(llag_pkg::CMD_STEP, 6'd0, 6'd0, 1'b0);
      send_item(llag_pkg::CMD_GET, 6'd63, 6'd1, 1'b0);
      for (int i = llag_pkg::CSR_SURVIVE_MASK + 1; i < 2 ** llag_pkg::CSR_IDX_W; i++) begin
         write_register(llag_pkg::CSR_IDX_W'(i), 9'd0);
      end
      send_item(llag_pkg::CMD_GET, 6'd2, 6'd1, 1'b0);
      write_register(llag_pkg::CSR_GRID_COLS, 9'd1);
      write_register(llag_pkg::CSR_GRID_ROWS, 9'd127);
      send_item(llag_pkg::CMD_GET, 6'd0, 6'd63, 1'b0);
   endtask

   task automatic test_rule_extremes();
      write_register(llag_pkg::CSR_GRID_COLS, 9'd4);
      write_register(llag_pkg::CSR_GRID_ROWS, 9'd3);
      write_register(llag_pkg::CSR_BIRTH_MASK, 9'h1FF);
      write_register(llag_pkg::CSR_SURVIVE_MASK, 9'h000);
      send_item(llag_pkg::CMD_STEP, 6'd0, 6'd0, 1'b0);
      send_item(llag_pkg::CMD_GET, 6'd3, 6'd2, 1'b0);
      write_register(llag_pkg::CSR_BIRTH_MASK, 9'h000);
      write_register(llag_pkg::CSR_SURVIVE_MASK, 9'h1FF);
      send_item(llag_pkg::CMD_STEP, 6'd0, 6'd0, 1'b0);
      send_item(llag_pkg::CMD_GET, 6'd0, 6'd0, 1'b0);
   endtask

   task automatic test_random_phases();
      int                           pick;
      int                           w;
      int                           h;
      logic [llag_pkg::SIZE_W-1:0]  cols;
      logic [llag_pkg::SIZE_W-1:0]  rows;
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         pick = $urandom_range(0, 9);
         case (pick)
            0: begin
               cols = (p % 2 == 0) ? 7'd0 : llag_pkg::SIZE_W'($urandom_range(1, 8));
               rows = (p % 2 == 0) ? llag_pkg::SIZE_W'($urandom_range(1, 8)) : 7'd0;
            end
            1: begin
               cols = llag_pkg::SIZE_W'($urandom_range(65, 127));
               rows = llag_pkg::SIZE_W'($urandom_range(1, 4));
            end
            2: begin
               cols = llag_pkg::SIZE_W'($urandom_range(1, 4));
               rows = llag_pkg::SIZE_W'($urandom_range(64, 127));
            end
            default: begin
               cols = llag_pkg::SIZE_W'($urandom_range(1, 12));
               rows = llag_pkg::SIZE_W'($urandom_range(1, 12));
            end
         endcase
         write_register(llag_pkg::CSR_GRID_COLS, {2'($urandom), cols});
         write_register(llag_pkg::CSR_GRID_ROWS, {2'($urandom), rows});
         if ($urandom_range(0, 1) == 0) begin
            write_register(llag_pkg::CSR_BIRTH_MASK, llag_pkg::BIRTH_MASK_RST);
            write_register(llag_pkg::CSR_SURVIVE_MASK, llag_pkg::SURVIVE_MASK_RST);
         end else begin
            write_register(llag_pkg::CSR_BIRTH_MASK, llag_pkg::CSR_DATA_W'($urandom));
            write_register(llag_pkg::CSR_SURVIVE_MASK, llag_pkg::CSR_DATA_W'($urandom));
         end
         w = cols_in_use();
         h = rows_in_use();
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 40) begin
               send_item(llag_pkg::CMD_SET, coord_within(w), coord_within(h),
                         1'($urandom_range(0, 2) != 0));
            end else if (pick < 55) begin
               send_item(llag_pkg::CMD_STEP, llag_pkg::COORD_W'($urandom),
                         llag_pkg::COORD_W'($urandom), 1'($urandom));
            end else if (pick < 88) begin
               send_item(llag_pkg::CMD_GET, coord_within(w), coord_within(h), 1'($urandom));
            end else if (pick < 97) begin
               send_item(llag_pkg::CMD_W'($urandom_range(0, 2)),
                         llag_pkg::COORD_W'($urandom), llag_pkg::COORD_W'($urandom),
                         1'($urandom));
            end else begin
               send_item(llag_pkg::CMD_FILL, llag_pkg::COORD_W'($urandom),
                         llag_pkg::COORD_W'($urandom), 1'($urandom));
            end
            if (i == PHASE_ITEMS / 2 && $urandom_range(0, 2) == 0) wait_until_quiet();
         end
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_reset_state();
      test_set_get_corners();
      test_fill_store();
      test_edge_step_full_grid();
      test_out_of_grid_cells();
      test_size_extremes();
      test_rule_extremes();
      test_random_phases();
      wait_until_quiet();
      if (mismatch_count == 0 && awaited_replies.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   // each reply beat is compared with the oldest prediction
   always @(posedge clock) begin
      cell_reply_type want;
      if (!reset && rsp_valid === 1'b1) begin
         if (awaited_replies.size() == 0) begin
            report_failure("reply beat with no command outstanding");
         end else begin
            want = awaited_replies.pop_front();
            if (rsp_ok !== want.ok)
               report_failure($sformatf("ok expected %0b got %0b", want.ok, rsp_ok));
            if (rsp_read_value !== want.read_value)
               report_failure($sformatf("read_value expected %0b got %0b",
                                        want.read_value, rsp_read_value));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && busy === 1'b0) || rsp_valid === 1'b1
          || (csr_valid && csr_ready === 1'b1)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

endmodule

`default_nettype wire

// ===== life_like_automaton_grid_unit.f =====
+incdir+src
src/llag_pkg.sv
src/llag_rule.sv
src/life_like_automaton_grid_unit.sv
src/llag_checker.sv
tb/sv/life_like_automaton_grid_unit_tb.sv
